FILE: hw/rtl/mrmix_pkg.sv
package mrmix_pkg;

  typedef enum logic [1:0] {
    MODE_FIXED_WING = 2'd0,
    MODE_QUAD_H     = 2'd1,
    MODE_TRI_Y      = 2'd2,
    MODE_UNKNOWN    = 2'd3
  } frame_mode_t;

  // configuration register indexes
  localparam logic [2:0] CFG_FRAME_MODE   = 3'd0;
  localparam logic [2:0] CFG_MAX_TORQUE   = 3'd1;
  localparam logic [2:0] CFG_SIGNAL_LIMIT = 3'd2;
  localparam logic [2:0] CFG_RP_GAIN      = 3'd3;
  localparam logic [2:0] CFG_YAW_GAIN     = 3'd4;
  localparam logic [2:0] CFG_SERVO_PERIOD = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // reset values
  localparam frame_mode_t RST_FRAME_MODE   = MODE_QUAD_H;
  localparam logic [14:0] RST_MAX_TORQUE   = 15'd512;
  localparam logic [9:0]  RST_SIGNAL_LIMIT = 10'd500;
  localparam logic [7:0]  RST_RP_GAIN      = 8'd20;
  localparam logic [7:0]  RST_YAW_GAIN     = 8'd70;
  localparam logic [15:0] RST_SERVO_PERIOD = 16'd65455;

  localparam int THROTTLE_IDLE  = 15;
  localparam int LEVEL_MAX      = 900;
  localparam int PWM_BASE       = 1000;
  localparam int PWM_SCALE      = 24;
  localparam int SERVO_CENTRE   = 1450;
  localparam int SERVO_FRAME_US = 20000;

  // floor(p / 20000) = (p * SCALE_RECIP) >> SCALE_SHIFT, exact for p below 2^28
  localparam int SCALE_SHIFT = 43;
  localparam logic [28:0] SCALE_RECIP =
    29'(((64'd1 << SCALE_SHIFT) + 64'(SERVO_FRAME_US) - 64'd1) / 64'(SERVO_FRAME_US));

  // per motor: bit 0 roll, bit 1 pitch, bit 2 yaw subtract
  localparam logic [2:0] MIX_NEG [4] = '{3'b100, 3'b001, 3'b010, 3'b111};

  localparam logic [4:0] MASK_FIXED_WING = 5'h01;
  localparam logic [4:0] MASK_QUAD_H     = 5'h0f;
  localparam logic [4:0] MASK_TRI_Y      = 5'h17;
  localparam logic [4:0] MASK_NONE       = 5'h00;

endpackage

FILE: hw/rtl/mrmix_axis.sv
module mrmix_axis (
  input  logic               clk,
  input  logic [2:0]         adv,
  input  logic signed [15:0] torque,
  input  logic [14:0]        max_torque,
  input  logic [7:0]         gain,
  input  logic [9:0]         signal_limit,
  output logic signed [10:0] delta
);

  logic signed [15:0] tq_r, tq_nxt;
  logic signed [24:0] prod_r, prod_nxt;
  logic signed [10:0] delta_r, delta_nxt;

  // clamp torque to +/- max_torque
  always_comb begin
    logic signed [16:0] t17;
    logic signed [16:0] lim17;
    t17   = 17'(torque);
    lim17 = signed'({2'b00, max_torque});
    if (t17 > lim17) begin
      tq_nxt = lim17[15:0];
    end else if (t17 < -lim17) begin
      tq_nxt = 16'(-lim17);
    end else begin
      tq_nxt = torque;
    end
  end

  assign prod_nxt = 25'(tq_r) * signed'({17'd0, gain});

  // negate, divide by 256 rounding toward zero, clamp to +/- signal_limit
  always_comb begin
    logic signed [24:0] neg;
    logic signed [16:0] q;
    logic signed [16:0] sl17;
    neg  = -prod_r;
    if (neg < 0) begin
      q = 17'((neg + 25'sd255) >>> 8);
    end else begin
      q = 17'(neg >>> 8);
    end
    sl17 = signed'({7'd0, signal_limit});
    if (q > sl17) begin
      delta_nxt = sl17[10:0];
    end else if (q < -sl17) begin
      delta_nxt = 11'(-sl17);
    end else begin
      delta_nxt = q[10:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) tq_r    <= tq_nxt;
    if (adv[1]) prod_r  <= prod_nxt;
    if (adv[2]) delta_r <= delta_nxt;
  end

  assign delta = delta_r;

endmodule

FILE: hw/rtl/mrmix_scale.sv
module mrmix_scale (
  input  logic        clk,
  input  logic        adv,
  input  logic [11:0] value,
  input  logic [15:0] period_counts,
  output logic [15:0] scaled
);

  logic [27:0] prod_r, prod_nxt;
  logic [56:0] recip_prod;

  assign prod_nxt = 28'(value) * 28'(period_counts);

  always_ff @(posedge clk) begin
    if (adv) prod_r <= prod_nxt;
  end

  // divide by the frame length through the reciprocal
  assign recip_prod = 57'(prod_r) * 57'(mrmix_pkg::SCALE_RECIP);
  assign scaled     = {2'b00, recip_prod[56:mrmix_pkg::SCALE_SHIFT]};

endmodule

FILE: hw/rtl/multirotor_motor_mixer_core.sv
// Multirotor motor mixer core.
// Input channel (in_valid/in_ready) takes one command request: throttle and
// signed Q8.8 roll, pitch and yaw torques. Output channel (out_valid/out_ready)
// returns one set of actuator compare values per request, with write_mask
// flagging which of motor_one..motor_four and yaw_servo are meaningful.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) sets frame mode,
// limits, gains and the servo period; cfg_ready is always high. Write it only
// while no request is in flight.
// Five register stages: torque clamp, gain multiply, scale and clamp, mix and
// period multiply, reciprocal divide. Throughput: one request per cycle, set by
// the fully pipelined datapath, while the receiver does not stall the output.
// Reset loads the register defaults (quad H frame) and empties the pipeline.
// When the receiver stalls, each stage holds its request; empty stages ahead
// of a stall keep filling, so in_ready only drops once every stage is full.
module multirotor_motor_mixer_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [9:0]                          in_throttle,
  input  logic signed [15:0]                  in_roll_torque,
  input  logic signed [15:0]                  in_pitch_torque,
  input  logic signed [15:0]                  in_yaw_torque,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [15:0]                         out_motor_one,
  output logic [15:0]                         out_motor_two,
  output logic [15:0]                         out_motor_three,
  output logic [15:0]                         out_motor_four,
  output logic [15:0]                         out_yaw_servo,
  output logic [4:0]                          out_write_mask,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mrmix_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrmix_pkg::CFG_DATA_W-1:0]    cfg_data
);

  mrmix_pkg::frame_mode_t frame_mode_r;
  logic [14:0] max_torque_r;
  logic [9:0]  signal_limit_r;
  logic [7:0]  rp_gain_r;
  logic [7:0]  yaw_gain_r;
  logic [15:0] servo_period_r;

  logic [5:1] v_r, v_nxt;
  logic [5:1] en;

  logic [9:0] thr1_r, thr2_r, thr3_r;

  logic signed [10:0] d_roll, d_pitch, d_yaw;

  logic [15:0] mot_nxt [4];
  logic [15:0] mot4_r [4];
  logic [4:0]  mask4_r, mask_nxt;
  logic        fw4_r, ty4_r;
  logic [11:0] scale_in;
  logic [15:0] scaled;

  logic [15:0] mot5_r [4];
  logic [15:0] servo5_r;
  logic [4:0]  mask5_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mode_r   <= mrmix_pkg::RST_FRAME_MODE;
      max_torque_r   <= mrmix_pkg::RST_MAX_TORQUE;
      signal_limit_r <= mrmix_pkg::RST_SIGNAL_LIMIT;
      rp_gain_r      <= mrmix_pkg::RST_RP_GAIN;
      yaw_gain_r     <= mrmix_pkg::RST_YAW_GAIN;
      servo_period_r <= mrmix_pkg::RST_SERVO_PERIOD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        mrmix_pkg::CFG_FRAME_MODE:   frame_mode_r   <= mrmix_pkg::frame_mode_t'(cfg_data[1:0]);
        mrmix_pkg::CFG_MAX_TORQUE:   max_torque_r   <= cfg_data[14:0];
        mrmix_pkg::CFG_SIGNAL_LIMIT: signal_limit_r <= cfg_data[9:0];
        mrmix_pkg::CFG_RP_GAIN:      rp_gain_r      <= cfg_data[7:0];
        mrmix_pkg::CFG_YAW_GAIN:     yaw_gain_r     <= cfg_data[7:0];
        mrmix_pkg::CFG_SERVO_PERIOD: servo_period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its successor loads too
  always_comb begin
    en[5] = !v_r[5] || out_ready;
    for (int k = 4; k >= 1; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt = v_r;
    if (en[1]) v_nxt[1] = in_valid;
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) v_nxt[k] = v_r[k-1];
    end
  end

  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  mrmix_axis u_roll (
    .clk          (clk),
    .adv          (en[3:1]),
    .torque       (in_roll_torque),
    .max_torque   (max_torque_r),
    .gain         (rp_gain_r),
    .signal_limit (signal_limit_r),
    .delta        (d_roll)
  );

  mrmix_axis u_pitch (
    .clk          (clk),
    .adv          (en[3:1]),
    .torque       (in_pitch_torque),
    .max_torque   (max_torque_r),
    .gain         (rp_gain_r),
    .signal_limit (signal_limit_r),
    .delta        (d_pitch)
  );

  mrmix_axis u_yaw (
    .clk          (clk),
    .adv          (en[3:1]),
    .torque       (in_yaw_torque),
    .max_torque   (max_torque_r),
    .gain         (yaw_gain_r),
    .signal_limit (signal_limit_r),
    .delta        (d_yaw)
  );

  // mix: throttle plus signed axis deltas, clamp, map to compare value
  always_comb begin
    logic signed [12:0] t_s;
    logic signed [12:0] r_s;
    logic signed [12:0] p_s;
    logic signed [12:0] y_s;
    logic signed [12:0] sum;
    logic [9:0]         lvl;
    logic               tri_y;
    t_s   = signed'(13'(thr3_r));
    r_s   = 13'(d_roll);
    p_s   = 13'(d_pitch);
    tri_y = (frame_mode_r == mrmix_pkg::MODE_TRI_Y);
    y_s   = tri_y ? 13'sd0 : 13'(d_yaw);
    for (int i = 0; i < 4; i++) begin
      sum = t_s
          + (mrmix_pkg::MIX_NEG[i][0] ? -r_s : r_s)
          + (mrmix_pkg::MIX_NEG[i][1] ? -p_s : p_s)
          + (mrmix_pkg::MIX_NEG[i][2] ? -y_s : y_s);
      if (thr3_r <= 10'(mrmix_pkg::THROTTLE_IDLE)) begin
        lvl = '0;
      end else if (sum < 0) begin
        lvl = '0;
      end else if (sum > 13'(mrmix_pkg::LEVEL_MAX)) begin
        lvl = 10'(mrmix_pkg::LEVEL_MAX);
      end else begin
        lvl = sum[9:0];
      end
      mot_nxt[i] = (16'(lvl) + 16'(mrmix_pkg::PWM_BASE)) * 16'(mrmix_pkg::PWM_SCALE);
    end
    case (frame_mode_r)
      mrmix_pkg::MODE_QUAD_H: begin
        mask_nxt = mrmix_pkg::MASK_QUAD_H;
      end
      mrmix_pkg::MODE_TRI_Y: begin
        mask_nxt   = mrmix_pkg::MASK_TRI_Y;
        mot_nxt[3] = '0;
      end
      mrmix_pkg::MODE_FIXED_WING: begin
        mask_nxt = mrmix_pkg::MASK_FIXED_WING;
        for (int i = 0; i < 4; i++) mot_nxt[i] = '0;
      end
      default: begin
        mask_nxt = mrmix_pkg::MASK_NONE;
        for (int i = 0; i < 4; i++) mot_nxt[i] = '0;
      end
    endcase
  end

  // servo centre plus yaw delta, or raw throttle in fixed wing
  always_comb begin
    logic signed [12:0] us_s;
    us_s = 13'(mrmix_pkg::SERVO_CENTRE) + 13'(d_yaw);
    if (frame_mode_r == mrmix_pkg::MODE_FIXED_WING) begin
      scale_in = 12'(thr3_r);
    end else begin
      scale_in = us_s[11:0];
    end
  end

  mrmix_scale u_scale (
    .clk           (clk),
    .adv           (en[4]),
    .value         (scale_in),
    .period_counts (servo_period_r),
    .scaled        (scaled)
  );

  always_ff @(posedge clk) begin
    if (en[1]) thr1_r <= in_throttle;
    if (en[2]) thr2_r <= thr1_r;
    if (en[3]) thr3_r <= thr2_r;
    if (en[4]) begin
      mot4_r  <= mot_nxt;
      mask4_r <= mask_nxt;
      fw4_r   <= (frame_mode_r == mrmix_pkg::MODE_FIXED_WING);
      ty4_r   <= (frame_mode_r == mrmix_pkg::MODE_TRI_Y);
    end
    if (en[5]) begin
      mot5_r[0] <= fw4_r ? scaled : mot4_r[0];
      mot5_r[1] <= mot4_r[1];
      mot5_r[2] <= mot4_r[2];
      mot5_r[3] <= mot4_r[3];
      servo5_r  <= ty4_r ? scaled : 16'd0;
      mask5_r   <= mask4_r;
    end
  end

  assign out_valid       = v_r[5];
  assign out_motor_one   = mot5_r[0];
  assign out_motor_two   = mot5_r[1];
  assign out_motor_three = mot5_r[2];
  assign out_motor_four  = mot5_r[3];
  assign out_yaw_servo   = servo5_r;
  assign out_write_mask  = mask5_r;

endmodule

FILE: dv/multirotor_motor_mixer_core_tb.sv
module multirotor_motor_mixer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrmix_pkg::*;

  localparam int CLK_HALF         = 10;
  localparam int RESET_CYCLES     = 5;
  localparam int PIPE_STAGES      = 5;
  localparam int DRAIN_CYCLES     = 12;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int HOLD_OFF_CYCLES  = 64;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int PRESSURE_ITEMS   = 32;
  localparam int NUM_PHASES       = 8;
  localparam int THROTTLE_TOP     = 1023;

  // index with no register behind it: the write must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  // per motor: roll, pitch, yaw sign
  localparam int MIX_SIGN [4][3] = '{
    '{ 1,  1, -1},
    '{-1,  1,  1},
    '{ 1, -1,  1},
    '{-1, -1, -1}
  };

  typedef struct {
    frame_mode_t mode;
    logic [14:0] max_torque;
    logic [9:0]  signal_limit;
    logic [7:0]  rp_gain;
    logic [7:0]  yaw_gain;
    logic [15:0] servo_period;
  } mixer_cfg_t;

  typedef struct {
    logic [15:0] motor_one;
    logic [15:0] motor_two;
    logic [15:0] motor_three;
    logic [15:0] motor_four;
    logic [15:0] yaw_servo;
    logic [4:0]  write_mask;
  } actuator_set_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [9:0]            in_throttle = '0;
  logic signed [15:0]    in_roll_torque = '0;
  logic signed [15:0]    in_pitch_torque = '0;
  logic signed [15:0]    in_yaw_torque = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [15:0]           out_motor_one;
  logic [15:0]           out_motor_two;
  logic [15:0]           out_motor_three;
  logic [15:0]           out_motor_four;
  logic [15:0]           out_yaw_servo;
  logic [4:0]            out_write_mask;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  actuator_set_t expected_actuators [$];
  mixer_cfg_t    active_cfg;
  int            mismatch_count = 0;
  int            results_checked = 0;
  bit            gaps_on = 1'b1;
  bit            stalls_on = 1'b1;
  bit            hold_off_req = 1'b0;

  multirotor_motor_mixer_core u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_throttle     (in_throttle),
    .in_roll_torque  (in_roll_torque),
    .in_pitch_torque (in_pitch_torque),
    .in_yaw_torque   (in_yaw_torque),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_motor_one   (out_motor_one),
    .out_motor_two   (out_motor_two),
    .out_motor_three (out_motor_three),
    .out_motor_four  (out_motor_four),
    .out_yaw_servo   (out_yaw_servo),
    .out_write_mask  (out_write_mask),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // ---------------------------------------------------------------- prediction

  function automatic int axis_signal(int torque, int gain, mixer_cfg_t c);
    int lim;
    int sl;
    int t;
    int d;
    lim = int'(c.max_torque);
    sl  = int'(c.signal_limit);
    t   = torque;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    // C-style division: truncate toward zero
    d = -(t * gain) / 256;
    if (d > sl) d = sl;
    if (d < -sl) d = -sl;
    return d;
  endfunction

  function automatic logic [15:0] period_counts(int unsigned us, logic [15:0] counts);
    longint unsigned prod;
    prod = us;
    prod = prod * counts;
    return 16'(prod / SERVO_FRAME_US);
  endfunction

  function automatic actuator_set_t predict_actuators(logic [9:0] thr,
                                                      logic signed [15:0] roll,
                                                      logic signed [15:0] pitch,
                                                      logic signed [15:0] yaw,
                                                      mixer_cfg_t c);
    actuator_set_t o;
    logic [15:0]   mot [4];
    int            d [3];
    int            lvl;
    int            nmot;
    int            m;
    o   = '{default: '0};
    mot = '{default: '0};
    case (c.mode)
      MODE_FIXED_WING: begin
        o.motor_one  = period_counts(int'(thr), c.servo_period);
        o.write_mask = MASK_FIXED_WING;
      end
      MODE_UNKNOWN: begin
        o.write_mask = MASK_NONE;
      end
      default: begin
        d[0] = axis_signal(int'(roll), int'(c.rp_gain), c);
        d[1] = axis_signal(int'(pitch), int'(c.rp_gain), c);
        d[2] = axis_signal(int'(yaw), int'(c.yaw_gain), c);
        nmot = (c.mode == MODE_QUAD_H) ? 4 : 3;
        for (m = 0; m < nmot; m++) begin
          lvl = 0;
          if (thr > THROTTLE_IDLE) begin
            lvl = int'(thr) + MIX_SIGN[m][0] * d[0] + MIX_SIGN[m][1] * d[1];
            if (nmot == 4) lvl += MIX_SIGN[m][2] * d[2];
            if (lvl < 0) lvl = 0;
            if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
          end
          mot[m] = 16'((PWM_BASE + lvl) * PWM_SCALE);
        end
        o.motor_one   = mot[0];
        o.motor_two   = mot[1];
        o.motor_three = mot[2];
        o.motor_four  = mot[3];
        if (nmot == 4) begin
          o.write_mask = MASK_QUAD_H;
        end else begin
          o.yaw_servo  = period_counts(SERVO_CENTRE + d[2], c.servo_period);
          o.write_mask = MASK_TRI_Y;
        end
      end
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s: expected %0d, got %0d",
                                results_checked, name, want, got));
  endtask

  // outputs are registered and out_ready moves only at the rising edge,
  // so the value seen here is the one the next edge takes
  always @(negedge clk) begin : check_results
    actuator_set_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_actuators.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                  results_checked));
      end else begin
        want = expected_actuators.pop_front();
        check_field("motor_one", want.motor_one, out_motor_one);
        check_field("motor_two", want.motor_two, out_motor_two);
        check_field("motor_three", want.motor_three, out_motor_three);
        check_field("motor_four", want.motor_four, out_motor_four);
        check_field("yaw_servo", want.yaw_servo, out_yaw_servo);
        check_field("write_mask", 16'(want.write_mask), 16'(out_write_mask));
      end
      results_checked++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("multirotor_motor_mixer_core_tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus helpers

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result sink: random stalls, plus one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 99) < 30) begin
        stall = pick_gap();
        if (stall == 0) stall = 1;
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // call at a rising edge; returns at a rising edge with valid either still
  // high (next request may follow at once) or already lowered after a gap
  task automatic offer_command(input logic [9:0] thr, input logic signed [15:0] roll,
                               input logic signed [15:0] pitch,
                               input logic signed [15:0] yaw);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_throttle     <= thr;
    in_roll_torque  <= roll;
    in_pitch_torque <= pitch;
    in_yaw_torque   <= yaw;
    do @(negedge clk); while (!in_ready);
    expected_actuators.push_back(predict_actuators(thr, roll, pitch, yaw, active_cfg));
    @(posedge clk);
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic end_requests();
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_torque(int lim);
    int span;
    span = lim + 64;
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1, 2:    return 16'($urandom);
      default: return 16'($urandom_range(0, 2 * span) - span);
    endcase
  endfunction

  function automatic logic [9:0] pick_throttle();
    case ($urandom_range(0, 9))
      0:       return 10'($urandom_range(0, 2 * THROTTLE_IDLE));
      1, 2:    return 10'($urandom_range(0, THROTTLE_TOP));
      default: return 10'($urandom_range(200, 800));
    endcase
  endfunction

  task automatic send_random_command();
    int lim;
    lim = int'(active_cfg.max_torque);
    offer_command(pick_throttle(), pick_torque(lim), pick_torque(lim), pick_torque(lim));
  endtask

  function automatic mixer_cfg_t random_settings(frame_mode_t mode);
    mixer_cfg_t c;
    c.mode         = mode;
    c.max_torque   = ($urandom_range(0, 3) == 0) ? 15'($urandom)
                                                 : 15'($urandom_range(32, 4096));
    c.signal_limit = ($urandom_range(0, 3) == 0) ? 10'($urandom)
                                                 : 10'($urandom_range(20, 600));
    c.rp_gain      = 8'($urandom);
    c.yaw_gain     = 8'($urandom);
    c.servo_period = 16'($urandom);
    return c;
  endfunction

  function automatic mixer_cfg_t limit_settings(frame_mode_t mode, bit top);
    mixer_cfg_t c;
    c.mode         = mode;
    c.max_torque   = top ? 15'h7fff : 15'd0;
    c.signal_limit = top ? 10'h3ff : 10'd0;
    c.rp_gain      = top ? 8'hff : 8'd0;
    c.yaw_gain     = top ? 8'hff : 8'd0;
    c.servo_period = top ? 16'hffff : 16'd1;
    return c;
  endfunction

  // unused upper bits carry noise; the block must ignore them
  function automatic logic [15:0] register_word(logic [CFG_IDX_W-1:0] idx, mixer_cfg_t c);
    logic [15:0] w;
    w = 16'($urandom);
    case (idx)
      CFG_FRAME_MODE:   w[1:0]  = c.mode;
      CFG_MAX_TORQUE:   w[14:0] = c.max_torque;
      CFG_SIGNAL_LIMIT: w[9:0]  = c.signal_limit;
      CFG_RP_GAIN:      w[7:0]  = c.rp_gain;
      CFG_YAW_GAIN:     w[7:0]  = c.yaw_gain;
      CFG_SERVO_PERIOD: w       = c.servo_period;
      default: ;
    endcase
    return w;
  endfunction

  function automatic void track_register_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] w);
    case (idx)
      CFG_FRAME_MODE:   active_cfg.mode         = frame_mode_t'(w[1:0]);
      CFG_MAX_TORQUE:   active_cfg.max_torque   = w[14:0];
      CFG_SIGNAL_LIMIT: active_cfg.signal_limit = w[9:0];
      CFG_RP_GAIN:      active_cfg.rp_gain      = w[7:0];
      CFG_YAW_GAIN:     active_cfg.yaw_gain     = w[7:0];
      CFG_SERVO_PERIOD: active_cfg.servo_period = w;
      default: ;
    endcase
  endfunction

  // write every register, only once the pipeline has drained
  task automatic apply_settings(input mixer_cfg_t c);
    logic [CFG_IDX_W-1:0] order [7];
    logic [15:0]          w;
    int                   i;
    order = '{CFG_FRAME_MODE, CFG_MAX_TORQUE, CFG_SIGNAL_LIMIT, CFG_RP_GAIN,
              CFG_YAW_GAIN, CFG_SERVO_PERIOD, CFG_UNMAPPED};
    while (expected_actuators.size() != 0) @(posedge clk);
    repeat (PIPE_STAGES) @(posedge clk);
    for (i = 0; i < 7; i++) begin
      w = register_word(order[i], c);
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= w;
      do @(negedge clk); while (!cfg_ready);
      track_register_write(order[i], w);
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  // reset settings: quad H, default limits and gains
  task automatic test_reset_defaults();
    offer_command(10'd0, 16'sd0, 16'sd0, 16'sd0);
    offer_command(10'd15, 16'sd300, -16'sd300, 16'sd100);
    offer_command(10'd16, 16'sd0, 16'sd0, 16'sd0);
    offer_command(10'd500, 16'sh7fff, 16'sh8000, 16'sh7fff);
    offer_command(10'd500, 16'sh8000, 16'sh7fff, 16'sh8000);
    offer_command(10'd1000, 16'sd0, 16'sd0, 16'sd0);
    offer_command(10'd1023, -16'sd1, 16'sd1, -16'sd1);
    offer_command(10'd450, 16'sd256, -16'sd256, 16'sd128);
    end_requests();
  endtask

  task automatic test_tri_y_frame();
    apply_settings(limit_settings(MODE_TRI_Y, 1'b1));
    offer_command(10'd0, 16'sd0, 16'sd0, 16'sh7fff);
    offer_command(10'd15, 16'sh7fff, 16'sd0, 16'sh8000);
    offer_command(10'd600, 16'sh8000, 16'sh7fff, 16'sh8000);
    offer_command(10'd600, 16'sh7fff, 16'sh8000, 16'sh7fff);
    offer_command(10'd300, 16'sd1000, 16'sd2000, -16'sd3000);
    end_requests();
  endtask

  task automatic test_fixed_wing();
    apply_settings(limit_settings(MODE_FIXED_WING, 1'b1));
    offer_command(10'd0, 16'sh7fff, 16'sh8000, 16'sd5);
    offer_command(10'd1023, 16'sh8000, 16'sh7fff, -16'sd5);
    end_requests();
    apply_settings(limit_settings(MODE_FIXED_WING, 1'b0));
    offer_command(10'd1023, 16'sd0, 16'sd0, 16'sd0);
    end_requests();
  endtask

  task automatic test_unknown_frame();
    apply_settings(random_settings(MODE_UNKNOWN));
    offer_command(10'd1023, 16'sh7fff, 16'sh8000, 16'sd0);
    offer_command(10'd0, 16'sd0, 16'sd0, 16'sd0);
    end_requests();
  endtask

  task automatic test_random_phases();
    frame_mode_t modes [NUM_PHASES];
    mixer_cfg_t  c;
    int          ph;
    modes = '{MODE_QUAD_H, MODE_TRI_Y, MODE_QUAD_H, MODE_TRI_Y,
              MODE_FIXED_WING, MODE_QUAD_H, MODE_TRI_Y, MODE_UNKNOWN};
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 0)      c = limit_settings(modes[ph], 1'b0);
      else if (ph == 1) c = limit_settings(modes[ph], 1'b1);
      else              c = random_settings(modes[ph]);
      // every third phase runs back to back on both sides
      gaps_on   = (ph % 3 != 2);
      stalls_on = (ph % 3 != 2);
      apply_settings(c);
      repeat (RANDOM_PER_PHASE) send_random_command();
      end_requests();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // hold the sink off while requests keep coming, so in_ready has to drop
  task automatic test_input_backpressure();
    apply_settings(random_settings(MODE_QUAD_H));
    gaps_on      = 1'b0;
    hold_off_req = 1'b1;
    repeat (PRESSURE_ITEMS) send_random_command();
    end_requests();
    gaps_on = 1'b1;
  endtask

  initial begin : stimulus
    active_cfg.mode         = RST_FRAME_MODE;
    active_cfg.max_torque   = RST_MAX_TORQUE;
    active_cfg.signal_limit = RST_SIGNAL_LIMIT;
    active_cfg.rp_gain      = RST_RP_GAIN;
    active_cfg.yaw_gain     = RST_YAW_GAIN;
    active_cfg.servo_period = RST_SERVO_PERIOD;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_tri_y_frame();
    test_fixed_wing();
    test_unknown_frame();
    test_input_backpressure();
    test_random_phases();

    while (expected_actuators.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("multirotor_motor_mixer_core_tb: clean");
    end else begin
      $display("multirotor_motor_mixer_core_tb: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mrmix_pkg.sv
hw/rtl/mrmix_axis.sv
hw/rtl/mrmix_scale.sv
hw/rtl/multirotor_motor_mixer_core.sv
dv/multirotor_motor_mixer_core_tb.sv
